FILE: rtl/sha256_sha224_hash_top_defines.svh
// Assertion helpers for the hash block.
`ifndef SHA256_SHA224_HASH_TOP_DEFINES_SVH
`define SHA256_SHA224_HASH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked on clk, off while arst_n is low.
`define SHA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Clocked on clk, checked during reset too.
`define SHA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA_ASSERT(lbl, prop, msg)
`define SHA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/sha2h_pkg.sv
`default_nettype none
package sha2h_pkg;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_t;

	typedef struct packed {
		logic start;
		logic init;
		logic mode;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

	localparam logic [31:0] IV256 [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

	localparam logic [31:0] IV224 [8] = '{
		32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
		32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

endpackage
`default_nettype wire

FILE: rtl/sha256_sha224_hash_top.sv
`default_nettype none
// Channel   Direction  Handshake          Payload
// in        into       in_valid/in_stall   sha2h_pkg::in_t  (op, data_byte)
// out       out of     out_valid/out_stall sha2h_pkg::out_t (digest_word, word_index, last_word)
// cfg       into       cfg_we              cfg_data (mode)
// Each append transfer writes one byte into the block buffer; the 64th byte of a block starts a compression
// (start, 64 rounds on the shared round unit, hash fold).
// A finish runs one compression, or two when the padding spills into a second block,
// then holds one digest word per out transfer (8 words, 7 in SHA-224 mode).
// in_stall stays high through a compression, and from a finish until the last word leaves.
// Reset loads the SHA-256 initial hash and clears the byte count; no clearing pass.
module sha256_sha224_hash_top (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  wire sha2h_pkg::in_t in_data,
	output logic             out_valid,
	input  wire              out_stall,
	output sha2h_pkg::out_t  out_data,
	input  wire              cfg_we,
	input  wire              cfg_data
);
	import sha2h_pkg::*;
	`include "sha256_sha224_hash_top_defines.svh"

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_BLK_GO  = 3'd1;
	localparam logic [2:0] S_BLK_WT  = 3'd2;
	localparam logic [2:0] S_P1_GO   = 3'd3;
	localparam logic [2:0] S_P1_WT   = 3'd4;
	localparam logic [2:0] S_P2_GO   = 3'd5;
	localparam logic [2:0] S_P2_WT   = 3'd6;
	localparam logic [2:0] S_OUT     = 3'd7;

	logic [2:0]  state_q;
	logic        mode_q;
	logic [63:0] cnt_q;
	logic [2:0]  wi_q;
	logic [31:0] buf_q [16];

	logic [5:0]      pos;
	logic [3:0]      lane;
	logic [1:0]      bsel;
	logic            in_xfer;
	logic            out_xfer;
	logic            last;
	logic [63:0]     bits;
	core_ctl_t       ctl;
	core_sts_t       sts;
	logic [7:0][31:0] hash;
	logic [15:0][31:0] blk;

	assign pos      = cnt_q[5:0];
	assign lane     = pos[5:2];
	assign bsel     = 2'd3 - pos[1:0];
	assign bits     = {cnt_q[60:0], 3'b000};
	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);
	assign out_xfer = out_valid && !out_stall;
	assign last     = (wi_q == (mode_q ? 3'd6 : 3'd7));

	// Keep bytes ahead of the fill point, drop in the 0x80 marker, zero the rest.
	function automatic logic [31:0] pad_word(input logic [31:0] w, input logic [1:0] p);
		logic [31:0] r;
		r = '0;
		for (int b = 0; b < 4; b++) begin
			if (b < p) r[31 - 8*b -: 8] = w[31 - 8*b -: 8];
			else if (b == p) r[31 - 8*b -: 8] = 8'h80;
		end
		return r;
	endfunction

	always_comb begin
		for (int i = 0; i < 16; i++) blk[i] = buf_q[i];
		ctl.start = (state_q == S_BLK_GO) || (state_q == S_P1_GO) || (state_q == S_P2_GO);
		ctl.init  = cfg_we || (out_xfer && last);
		ctl.mode  = cfg_we ? cfg_data : mode_q;
		out_data.digest_word = hash[wi_q];
		out_data.word_index  = wi_q;
		out_data.last_word   = last;
	end

	// Sequencer: appends, block compressions, padding passes, digest readout.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= 1'b0;
			cnt_q   <= '0;
			wi_q    <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
				cnt_q  <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (in_data.op == OP_APPEND) begin
							cnt_q <= cnt_q + 64'd1;
							if (pos == 6'd63) state_q <= S_BLK_GO;
						end else begin
							state_q <= (pos >= 6'd56) ? S_P1_GO : S_P2_GO;
						end
					end
				end
				S_BLK_GO: state_q <= S_BLK_WT;
				S_BLK_WT: if (sts.done) state_q <= S_IDLE;
				S_P1_GO:  state_q <= S_P1_WT;
				S_P1_WT:  if (sts.done) state_q <= S_P2_GO;
				S_P2_GO:  state_q <= S_P2_WT;
				S_P2_WT: begin
					if (sts.done) begin
						state_q <= S_OUT;
						wi_q    <= '0;
					end
				end
				S_OUT: begin
					if (out_xfer) begin
						wi_q <= wi_q + 3'd1;
						if (last) begin
							state_q <= S_IDLE;
							cnt_q   <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Block buffer: byte writes, padding, and the length words.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_xfer) begin
			if (in_data.op == OP_APPEND) begin
				buf_q[lane][{bsel, 3'b000} +: 8] <= in_data.data_byte;
			end else begin
				for (int i = 0; i < 16; i++) begin
					if (i == int'(lane)) buf_q[i] <= pad_word(buf_q[i], pos[1:0]);
					else if (i > int'(lane)) buf_q[i] <= '0;
				end
				if (pos < 6'd56) begin
					buf_q[14] <= bits[63:32];
					buf_q[15] <= bits[31:0];
				end
			end
		end else if (state_q == S_P1_WT && sts.done) begin
			for (int i = 0; i < 14; i++) buf_q[i] <= '0;
			buf_q[14] <= bits[63:32];
			buf_q[15] <= bits[31:0];
		end
	end

	sha2h_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.blk    (blk),
		.sts    (sts),
		.hash   (hash)
	);

	`SHA_ASSERT(a_busy_stalls, sts.busy |-> in_stall, "core busy while input open")
	`SHA_ASSERT(a_finish_quiet, (in_xfer && in_data.op == OP_FINISH) |=> !out_valid, "digest too early")
	`SHA_ASSERT(a_no_restart, ctl.start |-> !sts.busy, "core restarted while busy")
	`SHA_ASSERT(a_last_idx, (out_xfer && last) |-> (wi_q == 3'd6 || wi_q == 3'd7), "bad last word index")

endmodule
`default_nettype wire

FILE: rtl/sha2h_core.sv
`default_nettype none
module sha2h_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire sha2h_pkg::core_ctl_t ctl,
	input  wire [15:0][31:0]      blk,
	output sha2h_pkg::core_sts_t  sts,
	output logic [7:0][31:0]      hash
);
	import sha2h_pkg::*;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	logic [31:0] hash_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic        fin_q;

	logic [31:0] t1, t2, ch, maj, s0, s1, w_new;

	always_comb begin
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1    = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ch + ROUND_K[rnd_q] + w_q[0];
		t2    = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22)) + maj;
		s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
	end

	// Control: one round per cycle, then a fold into the hash in the cycle after the last round.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			rnd_q  <= '0;
			hash_q <= IV256;
		end else begin
			fin_q <= 1'b0;
			if (ctl.init) begin
				hash_q <= ctl.mode ? IV224 : IV256;
			end else if (fin_q) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
			end
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			v_q <= hash_q;
			for (int i = 0; i < 16; i++) w_q[i] <= blk[i];
		end else if (busy_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) hash[i] = hash_q[i];
		sts.busy = busy_q | fin_q;
		sts.done = fin_q;
	end

endmodule
`default_nettype wire

FILE: sim/sha256_sha224_hash_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module sha256_sha224_hash_top_tb;
	import sha2h_pkg::*;

	// stimulus table row: op, byte, and optional typed-in first digest word
	typedef struct {
		logic        op;
		logic [7:0]  data_byte;
		logic        has_word0;
		logic [31:0] word0;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_stall;
	in_t     in_data;
	logic    out_valid;
	logic    out_stall;
	out_t    out_data;
	logic    cfg_we;
	logic    cfg_data;

	// predictor state
	logic        pred_mode;
	logic [31:0] pred_hash [8];
	logic [31:0] pred_block [16];
	logic [63:0] pred_count;

	out_t        digest_q [$];
	int          fail_count;
	int          words_seen;
	int          msgs_done;
	int          items_sent;
	bit          idle_off;
	bit          hold_off_req;
	stim_row_t   stim_tbl [$];

	sha256_sha224_hash_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [31:0] rot_r(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression of pred_block into pred_hash
	task automatic run_rounds();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = pred_block[i];
		for (int i = 16; i < 64; i++) begin
			s0 = rot_r(w[i-15], 7) ^ rot_r(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rot_r(w[i-2], 17) ^ rot_r(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (int i = 0; i < 8; i++)
			v[i] = pred_hash[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rot_r(v[4], 6) ^ rot_r(v[4], 11) ^ rot_r(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
			t2 = (rot_r(v[0], 2) ^ rot_r(v[0], 13) ^ rot_r(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			pred_hash[i] += v[i];
	endtask

	task automatic restart_message();
		for (int i = 0; i < 8; i++)
			pred_hash[i] = pred_mode ? IV224[i] : IV256[i];
		pred_count = '0;
	endtask

	// advance the predictor by one accepted item; queue any digest words
	task automatic hash_item(in_t item);
		int unsigned pos, sh, nwords;
		logic [31:0] keep;
		logic [63:0] bits;
		out_t        dw;
		pos = pred_count[5:0];
		sh  = 24 - 8 * (pos % 4);
		if (item.op == OP_APPEND) begin
			pred_block[pos/4] = (pred_block[pos/4] & ~(32'hFF << sh))
				| (32'(item.data_byte) << sh);
			pred_count++;
			if (pos == 63)
				run_rounds();
			return;
		end
		keep = (sh == 24) ? 32'h0 : (32'hFFFFFFFF << (sh + 8));
		pred_block[pos/4] = (pred_block[pos/4] & keep) | (32'h80 << sh);
		for (int i = pos/4 + 1; i < 16; i++)
			pred_block[i] = '0;
		if (pos >= 56) begin
			run_rounds();
			for (int i = 0; i < 14; i++)
				pred_block[i] = '0;
		end
		bits = pred_count << 3;
		pred_block[14] = bits[63:32];
		pred_block[15] = bits[31:0];
		run_rounds();
		nwords = pred_mode ? 7 : 8;
		for (int i = 0; i < nwords; i++) begin
			dw.digest_word = pred_hash[i];
			dw.word_index  = 3'(i);
			dw.last_word   = (i + 1 == nwords);
			digest_q.push_back(dw);
		end
		restart_message();
	endtask

	// write mode while idle; drop valid and wait out any compression still in flight
	task automatic write_mode(logic m);
		in_valid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= m;
		@(negedge clk);
		cfg_we   <= 1'b0;
		pred_mode = m;
		restart_message();
	endtask

	// offer one item, with a random gap first unless idling is switched off
	task automatic send_item(logic op, logic [7:0] b);
		in_t item;
		if (!idle_off && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		item.op        = op;
		item.data_byte = b;
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		hash_item(item);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_message(int len);
		for (int i = 0; i < len; i++)
			send_item(OP_APPEND, 8'($urandom()));
		send_item(OP_FINISH, 8'($urandom()));
	endtask

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				hold_off_req = 1'b0;
			end
			if (!idle_off && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// check each word transfer against the oldest expected word
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (digest_q.size() == 0) begin
				$error("digest word with none expected: %h", out_data.digest_word);
				fail_count++;
			end else begin
				want = digest_q.pop_front();
				words_seen++;
				if (out_data.digest_word !== want.digest_word) begin
					$error("digest_word: expected %h, got %h",
						want.digest_word, out_data.digest_word);
					fail_count++;
				end
				if (out_data.word_index !== want.word_index) begin
					$error("word_index: expected %0d, got %0d",
						want.word_index, out_data.word_index);
					fail_count++;
				end
				if (out_data.last_word !== want.last_word) begin
					$error("last_word: expected %0d, got %0d",
						want.last_word, out_data.last_word);
					fail_count++;
				end
				if (want.last_word)
					msgs_done++;
			end
		end
	end

	// watchdog
	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic stim_row_t row(logic op, logic [7:0] b, logic has, logic [31:0] w0);
		stim_row_t r;
		r.op = op; r.data_byte = b; r.has_word0 = has; r.word0 = w0;
		return r;
	endfunction

	initial begin
		int drain;
		int first_idx;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_we       = 1'b0;
		cfg_data     = 1'b0;
		fail_count   = 0;
		words_seen   = 0;
		msgs_done    = 0;
		items_sent   = 0;
		idle_off     = 1'b0;
		hold_off_req = 1'b0;
		pred_mode    = 1'b0;
		for (int i = 0; i < 16; i++)
			pred_block[i] = '0;
		restart_message();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty message and "abc" in SHA-256, extremes of the byte field
		stim_tbl.push_back(row(OP_FINISH, 8'hFF, 1'b1, 32'hE3B0C442));
		stim_tbl.push_back(row(OP_APPEND, 8'h61, 1'b0, '0));
		stim_tbl.push_back(row(OP_APPEND, 8'h62, 1'b0, '0));
		stim_tbl.push_back(row(OP_APPEND, 8'h63, 1'b0, '0));
		stim_tbl.push_back(row(OP_FINISH, 8'h00, 1'b1, 32'hBA7816BF));
		stim_tbl.push_back(row(OP_APPEND, 8'h00, 1'b0, '0));
		stim_tbl.push_back(row(OP_APPEND, 8'hFF, 1'b0, '0));
		stim_tbl.push_back(row(OP_APPEND, 8'hAA, 1'b0, '0));
		stim_tbl.push_back(row(OP_APPEND, 8'h55, 1'b0, '0));
		stim_tbl.push_back(row(OP_FINISH, 8'h5A, 1'b0, '0));
		foreach (stim_tbl[k]) begin
			first_idx = digest_q.size();
			send_item(stim_tbl[k].op, stim_tbl[k].data_byte);
			if (stim_tbl[k].has_word0 && digest_q.size() > first_idx
				&& digest_q[first_idx].digest_word !== stim_tbl[k].word0) begin
				$error("digest_word: expected %h, got %h",
					stim_tbl[k].word0, digest_q[first_idx].digest_word);
				fail_count++;
			end
		end

		// SHA-224: empty message, first word known
		write_mode(1'b1);
		first_idx = digest_q.size();
		send_item(OP_FINISH, 8'h00);
		if (digest_q[first_idx].digest_word !== 32'hD14A028C) begin
			$error("digest_word: expected %h, got %h", 32'hD14A028C,
				digest_q[first_idx].digest_word);
			fail_count++;
		end
		// abandon a partial message by rewriting the same mode
		send_item(OP_APPEND, 8'h12);
		send_item(OP_APPEND, 8'h34);
		write_mode(1'b1);
		// padding spill lengths around the block boundary
		send_message(55);
		send_message(56);
		send_message(64);

		// long hold-off on the receiver while short messages keep coming
		hold_off_req = 1'b1;
		for (int m = 0; m < 4; m++)
			send_message($urandom_range(0, 3));

		// random messages, switching mode between some of them
		write_mode(1'b0);
		while (items_sent < 450) begin
			if (items_sent > 400)
				idle_off = 1'b1;
			if ($urandom_range(0, 7) == 0)
				write_mode(1'($urandom()));
			if ($urandom_range(0, 9) == 0)
				send_item(OP_FINISH, 8'($urandom()));
			else
				send_message($urandom_range(0, 4) == 0 ? $urandom_range(50, 70)
					: $urandom_range(0, 20));
		end
		in_valid <= 1'b0;

		drain = 0;
		while (digest_q.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (200) @(posedge clk);
		if (digest_q.size() != 0) begin
			$error("%0d digest words never arrived", digest_q.size());
			fail_count++;
		end
		$display("Hashed %0d items into %0d digests (%0d words) over both modes.",
			items_sent, msgs_done, words_seen);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
